### hw/rtl/irta_pkg.sv
// ----------------------------------------------------------------------------
// irta_pkg
// Shared types, character codes and helpers for the integer to ASCII printer.
// ----------------------------------------------------------------------------
package irta_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int PTR_W       = $clog2(VALUE_WIDTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // reciprocal of ten, exact quotient for any 32-bit dividend after >> 35
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_MUL,
    ST_DIV,
    ST_SIGN,
    ST_PFX0,
    ST_PFXX,
    ST_DIG
  } back_state_t;

  // one classified number on its way from front to back
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] mag;
    logic                   neg;
    radix_t                 base;
  } irta_item_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

### hw/rtl/irta_front.sv
// ----------------------------------------------------------------------------
// irta_front
// Holds the radix register, picks the base and sign of each request and
// forms the magnitude that the back end converts.
// ----------------------------------------------------------------------------
module irta_front import irta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value_bits
  input  logic [1:0]  s_axis_tuser,  // is_signed, force_hex
  output logic        push_valid,
  input  logic        push_ready,
  output irta_item_t  push_item
);

  radix_t                 radix;
  logic [VALUE_WIDTH-1:0] value;
  logic                   neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_DEC;
    end else if (cfg_wr_en) begin
      radix <= radix_t'(cfg_wr_data);
    end
  end

  assign value = s_axis_tdata[VALUE_WIDTH-1:0];
  assign neg   = s_axis_tuser[0] & value[VALUE_WIDTH-1];

  // the most negative value comes out right as an unsigned magnitude
  always_comb begin
    push_item.neg  = neg;
    push_item.mag  = neg ? (~value + 1'b1) : value;
    push_item.base = s_axis_tuser[1] ? RADIX_HEX : radix;
  end

  assign push_valid    = s_axis_tvalid;
  assign s_axis_tready = push_ready;

endmodule

### hw/rtl/irta_queue.sv
// ----------------------------------------------------------------------------
// irta_queue
// Short first-in first-out queue of classified requests between the front
// and back ends.
// ----------------------------------------------------------------------------
module irta_queue import irta_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  irta_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output irta_item_t pop_item
);

  irta_item_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/irta_back.sv
// ----------------------------------------------------------------------------
// irta_back
// Splits a magnitude into digits, least significant first, into a digit
// buffer, then sends sign, prefix and digits out most significant first.
// ----------------------------------------------------------------------------
module irta_back import irta_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  irta_item_t pop_item,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // ascii_char
  output logic       m_axis_tlast   // last_char
);

  back_state_t            state;
  back_state_t            state_next;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg;
  radix_t                 base;
  logic [PTR_W-1:0]       ptr;
  logic [3:0]             digits [VALUE_WIDTH];
  logic [63:0]            prod;

  logic                   out_free;
  logic                   has_pfx;
  back_state_t            first_out;
  logic [VALUE_WIDTH-1:0] mag_shift;
  logic [3:0]             pow2_digit;
  logic [28:0]            quot;
  logic [VALUE_WIDTH-1:0] rem_full;
  logic                   dig_we;
  logic [3:0]             dig_wdata;
  logic                   dig_more;
  logic [VALUE_WIDTH-1:0] mag_new;
  logic                   emit;
  logic [7:0]             emit_char;
  logic                   emit_last;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign has_pfx  = (base == RADIX_OCT) || (base == RADIX_HEX);

  always_comb begin
    if (neg) begin
      first_out = ST_SIGN;
    end else if (has_pfx) begin
      first_out = ST_PFX0;
    end else begin
      first_out = ST_DIG;
    end
  end

  // power-of-two bases peel bits off the bottom
  always_comb begin
    unique case (base)
      RADIX_BIN: begin
        mag_shift  = mag >> 1;
        pow2_digit = {3'd0, mag[0]};
      end
      RADIX_OCT: begin
        mag_shift  = mag >> 3;
        pow2_digit = {1'b0, mag[2:0]};
      end
      RADIX_HEX: begin
        mag_shift  = mag >> 4;
        pow2_digit = mag[3:0];
      end
      default: begin
        mag_shift  = '0;
        pow2_digit = '0;
      end
    endcase
  end

  // decimal: quotient from the registered product, remainder by shift-add
  assign quot     = prod[63:RECIP_SHIFT];
  assign rem_full = mag - ({quot, 3'd0} + {2'd0, quot, 1'd0});

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          state_next = (pop_item.base == RADIX_DEC) ? ST_MUL : ST_CONV;
        end
      end
      ST_CONV: begin
        if (mag_shift == '0) begin
          state_next = first_out;
        end
      end
      ST_MUL: state_next = ST_DIV;
      ST_DIV: begin
        state_next = (quot == '0) ? first_out : ST_MUL;
      end
      ST_SIGN: begin
        if (out_free) begin
          state_next = has_pfx ? ST_PFX0 : ST_DIG;
        end
      end
      ST_PFX0: begin
        if (out_free) begin
          state_next = (base == RADIX_HEX) ? ST_PFXX : ST_DIG;
        end
      end
      ST_PFXX: begin
        if (out_free) begin
          state_next = ST_DIG;
        end
      end
      ST_DIG: begin
        if (out_free && ptr == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    dig_we    = 1'b0;
    dig_wdata = '0;
    dig_more  = 1'b0;
    mag_new   = mag;
    emit      = 1'b0;
    emit_char = CHAR_ZERO;
    emit_last = 1'b0;
    unique case (state)
      ST_IDLE: pop_ready = 1'b1;
      ST_CONV: begin
        dig_we    = 1'b1;
        dig_wdata = pow2_digit;
        dig_more  = (mag_shift != '0);
        mag_new   = mag_shift;
      end
      ST_MUL: ;
      ST_DIV: begin
        dig_we    = 1'b1;
        dig_wdata = rem_full[3:0];
        dig_more  = (quot != '0);
        mag_new   = {3'd0, quot};
      end
      ST_SIGN: begin
        emit      = out_free;
        emit_char = CHAR_MINUS;
      end
      ST_PFX0: begin
        emit      = out_free;
        emit_char = CHAR_ZERO;
      end
      ST_PFXX: begin
        emit      = out_free;
        emit_char = CHAR_X;
      end
      ST_DIG: begin
        emit      = out_free;
        emit_char = digit_char(digits[ptr]);
        emit_last = (ptr == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      mag  <= pop_item.mag;
      neg  <= pop_item.neg;
      base <= pop_item.base;
      ptr  <= '0;
    end else begin
      mag <= mag_new;
      if (dig_we && dig_more) begin
        ptr <= ptr + 1'b1;
      end else if (emit && state == ST_DIG && ptr != '0) begin
        ptr <= ptr - 1'b1;
      end
    end
    if (state == ST_MUL) begin
      prod <= mag * RECIP_10;
    end
    if (dig_we) begin
      digits[ptr] <= dig_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= emit_char;
      m_axis_tlast <= emit_last;
    end
  end

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem_full < VALUE_WIDTH'(10))
    else $error("decimal remainder out of range");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    emit && emit_last |=> state == ST_IDLE)
    else $error("run did not end after its last character");

  a_dec_not_shifted: assert property (@(posedge clk) disable iff (rst)
    state == ST_CONV |-> base != RADIX_DEC)
    else $error("decimal number on the shift path");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |=> $stable(neg) && $stable(base))
    else $error("number changed during conversion");

endmodule

### hw/rtl/integer_radix_to_ascii_core.sv
// ----------------------------------------------------------------------------
// integer_radix_to_ascii_core
// Prints 32-bit integers as ASCII text in binary, octal, decimal or hex.
// ----------------------------------------------------------------------------
//  channel   direction  signals                      contents
//  s_axis    in         tvalid tready tdata tuser    tdata value_bits,
//                                                    tuser {force_hex, is_signed}
//  m_axis    out        tvalid tready tdata tlast    tdata ascii_char,
//                                                    tlast last_char
//  cfg       in         cfg_wr_en cfg_wr_data        radix_select
//
//  one number at a time in the converter: it is loaded, then its digits are
//  peeled off by shifts for binary, octal and hex, or by a multiply by the
//  reciprocal and then a remainder step for decimal, then its characters are sent
//  the front queue holds two more numbers while a conversion runs
//  rst is synchronous, active high; radix_select resets to decimal
//  a stalled output holds the character and pauses the sequencer only
// ----------------------------------------------------------------------------
module integer_radix_to_ascii_core import irta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value_bits
  input  logic [1:0]  s_axis_tuser,  // is_signed, force_hex
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // ascii_char
  output logic        m_axis_tlast   // last_char
);

  logic       push_valid;
  logic       push_ready;
  irta_item_t push_item;
  logic       pop_valid;
  logic       pop_ready;
  irta_item_t pop_item;

  irta_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  irta_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  irta_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to ASCII printer: drives numbers with
// random signedness and forced hex under every radix, predicts each character
// run and compares it character by character, under random idling on both
// sides, a long output hold-off and drain pauses around radix changes.
// ----------------------------------------------------------------------------
module tb_top;
  import irta_pkg::*;

  localparam logic [7:0] ASC_ZERO    = 8'h30;
  localparam logic [7:0] ASC_X       = 8'h78;
  localparam logic [7:0] ASC_UPPER_A = 8'h41;
  localparam logic [7:0] ASC_MINUS   = 8'h2D;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_exp_t;

  // expected characters of every accepted number, oldest first
  class numeral_scoreboard;
    char_exp_t   pending_chars[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    function int unsigned outstanding();
      return pending_chars.size();
    endfunction

    function void note_number(input logic [31:0] word, input logic is_signed,
                              input logic force_hex, input radix_t radix);
      logic [31:0] mag;
      logic [31:0] d;
      int unsigned base;
      logic [7:0]  digit_run[$];
      char_exp_t   run[$];
      char_exp_t   c;
      if (force_hex) begin
        base = 16;
      end else begin
        case (radix)
          RADIX_BIN: base = 2;
          RADIX_OCT: base = 8;
          RADIX_DEC: base = 10;
          default:   base = 16;
        endcase
      end
      mag = word;
      c.last = 1'b0;
      if (is_signed && word[31]) begin
        c.ch = ASC_MINUS;
        run.push_back(c);
        mag = ~word + 32'd1;
      end
      if (base == 8 || base == 16) begin
        c.ch = ASC_ZERO;
        run.push_back(c);
      end
      if (base == 16) begin
        c.ch = ASC_X;
        run.push_back(c);
      end
      // digits come out least significant first
      do begin
        d = mag % base;
        mag = mag / base;
        digit_run.push_front(d < 10 ? ASC_ZERO + d[7:0] : ASC_UPPER_A + d[7:0] - 8'd10);
      end while (mag != 0);
      foreach (digit_run[i]) begin
        c.ch = digit_run[i];
        run.push_back(c);
      end
      run[run.size()-1].last = 1'b1;
      foreach (run[i]) pending_chars.push_back(run[i]);
    endfunction

    task check_char(input logic [7:0] ch, input logic last);
      char_exp_t e;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last %b", ch, last));
      end else begin
        e = pending_chars.pop_front();
        if (ch !== e.ch)
          report_mismatch($sformatf("char %h, expected %h", ch, e.ch));
        if (last !== e.last)
          report_mismatch($sformatf("last %b, expected %b (char %h)", last, e.last, e.ch));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // value_bits
  logic [1:0]  s_axis_tuser;   // is_signed, force_hex
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // ascii_char
  logic        m_axis_tlast;   // last_char

  numeral_scoreboard sb = new();
  radix_t      radix_now;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_len;

  integer_radix_to_ascii_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL integer_radix_to_ascii_core");
    $finish;
  end

  // output side: random stalls, plus a counted hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        m_axis_tready <= 1'b0;
        hold_len--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_char(m_axis_tdata, m_axis_tlast);
  end

  task send_number(input logic [31:0] word, input logic is_signed, input logic force_hex);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= {force_hex, is_signed};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_number(word, is_signed, force_hex, radix_now);
  endtask

  task wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task write_radix(input radix_t r);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radix_now = r;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] w;
    case ($urandom_range(6))
      0: w = $urandom_range(20);
      1: w = 32'h8000_0000 + $urandom_range(3);
      2: w = 32'h7FFF_FFFF - $urandom_range(3);
      3: w = 32'hFFFF_FFFF - $urandom_range(20);
      4: w = (32'd1 << $urandom_range(31)) - $urandom_range(1);
      default: w = $urandom();
    endcase
    return w;
  endfunction

  initial begin
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= RADIX_DEC;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    radix_now     = RADIX_DEC;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len      = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // decimal straight out of reset: zero, both extremes, signed and forced hex
    send_number(32'd0, 1'b0, 1'b0);
    send_number(32'd0, 1'b1, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_number(32'h8000_0000, 1'b1, 1'b0);
    send_number(32'h8000_0000, 1'b0, 1'b0);
    send_number(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_number(32'd1234567890, 1'b0, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b0, 1'b1);
    send_number(32'h8000_0000, 1'b1, 1'b1);
    send_number(32'd0, 1'b0, 1'b1);
    wait_drained();
    write_radix(RADIX_BIN);
    send_number(32'd0, 1'b0, 1'b0);
    send_number(32'd1, 1'b1, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b0, 1'b0);
    // longest run: sign plus 32 binary digits
    send_number(32'h8000_0000, 1'b1, 1'b0);
    send_number(32'hAAAA_5555, 1'b1, 1'b1);
    wait_drained();
    write_radix(RADIX_OCT);
    send_number(32'd0, 1'b0, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_number(32'h8000_0000, 1'b1, 1'b0);
    send_number(32'd8, 1'b0, 1'b0);
    wait_drained();
    write_radix(RADIX_HEX);
    send_number(32'd0, 1'b0, 1'b0);
    send_number(32'hDEAD_BEEF, 1'b1, 1'b0);
    send_number(32'h0123_ABCD, 1'b0, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b1, 1'b1);

    for (int blk = 0; blk < 9; blk++) begin
      case (blk / 3)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_drained();
      write_radix(radix_t'(2'(blk % 4)));
      // output blocked for a long stretch while requests keep coming
      if (blk == 6) hold_len = 300;
      repeat (50) send_number(pick_value(), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end

    wait_drained();
    repeat (120) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS integer_radix_to_ascii_core");
    end else begin
      $display("FAIL integer_radix_to_ascii_core");
    end
    $finish;
  end

endmodule
